### rtl/core/lem_pkg.sv
// ----------------------------------------------------------------------------
// lem_pkg
// Types and constants for the light exposure monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package lem_pkg;

  // correction coefficients, Q.48
  localparam logic signed [63:0] COEF_A = 64'sd169;
  localparam logic signed [63:0] COEF_B = -64'sd2643726;
  localparam logic signed [63:0] COEF_C = 64'sd22936832902;
  localparam logic signed [63:0] COEF_D = 64'sd282122369157091;

  localparam logic [15:0] LUX_MAX = 16'hFFFF;

  localparam logic [1:0] REG_CATEGORY = 2'd0;
  localparam logic [1:0] REG_IDEAL    = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  localparam logic [2:0] CAT_LOW_LIGHT    = 3'd1;
  localparam logic [2:0] CAT_MEDIUM_LIGHT = 3'd2;
  localparam logic [2:0] CAT_BRIGHT_LIGHT = 3'd3;
  localparam logic [2:0] CAT_FULL_SUN     = 3'd4;

  typedef struct packed {
    logic [16:0] high;
    logic [16:0] low;
  } band_t;

  function automatic band_t band_of(input logic [2:0] cat);
    band_t b;
    case (cat)
      CAT_LOW_LIGHT:    b = '{high: 17'd1076,  low: 17'd270};
      CAT_MEDIUM_LIGHT: b = '{high: 17'd5382,  low: 17'd1076};
      CAT_BRIGHT_LIGHT: b = '{high: 17'd10764, low: 17'd5382};
      CAT_FULL_SUN:     b = '{high: 17'd99999, low: 17'd10750};
      default:          b = '{high: 17'd0,     low: 17'd0};
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lem_if.sv
// ----------------------------------------------------------------------------
// lem_in_if / lem_out_if
// Valid/ready channels for raw readings and slot results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lem_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_first;
  logic [15:0] raw_second;
  logic [15:0] raw_third;
  modport source (output valid, raw_first, raw_second, raw_third, input ready);
  modport sink (input valid, raw_first, raw_second, raw_third, output ready);
endinterface

interface lem_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] slot_lux;
  logic [7:0]  slot_number;
  logic        day_closed;
  logic        too_bright;
  logic        too_dark;
  logic        too_little_time;
  logic        too_much_time;
  modport source (output valid, slot_lux, slot_number, day_closed, too_bright,
                  too_dark, too_little_time, too_much_time, input ready);
  modport sink (input valid, slot_lux, slot_number, day_closed, too_bright,
                too_dark, too_little_time, too_much_time, output ready);
endinterface

`default_nettype wire

### rtl/core/lem_lux_unit.sv
// ----------------------------------------------------------------------------
// lem_lux_unit
// Converts one raw count to lux; scaled values above 1000 are corrected with
// a shared multiplier, one Horner step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lem_lux_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] raw,
  output logic             done,
  output logic [15:0]      lux
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_H1    = 3'd2;
  localparam logic [2:0] S_H2    = 3'd3;
  localparam logic [2:0] S_H3    = 3'd4;
  localparam logic [2:0] S_FIN1  = 3'd5;
  localparam logic [2:0] S_FIN2  = 3'd6;

  logic [2:0]         state;
  logic [14:0]        x;
  logic signed [63:0] p;
  logic [63:0]        acc;
  logic [15:0]        raw_q;

  // raw*168/625 via reciprocal: floor(v*27487791/2^34) exact for v < 2^26
  logic [23:0] scaled;
  logic [48:0] recip;
  logic [14:0] x_calc;
  assign scaled = 24'(raw_q) * 24'd168;
  assign recip  = 49'(scaled) * 49'd27487791;
  assign x_calc = 15'(recip >> 34);

  // shared multiply: 64 x 15 (signed by unsigned x)
  logic signed [63:0] mul_a;
  logic signed [78:0] mul_p;
  assign mul_p = 79'(mul_a) * $signed({64'd0, x});

  always_comb begin
    mul_a = p;
    if (state == S_FIN1) mul_a = $signed({40'd0, p[23:0]});
    else if (state == S_FIN2) mul_a = $signed({24'd0, p[63:24]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          raw_q <= raw;
          state <= S_SCALE;
        end
        S_SCALE: begin
          x <= x_calc;
          p <= lem_pkg::COEF_A;
          if (x_calc <= 15'd1000) begin
            lux   <= 16'(x_calc);
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_H1;
          end
        end
        S_H1: begin
          p     <= 64'(mul_p) + lem_pkg::COEF_B;
          state <= S_H2;
        end
        S_H2: begin
          p     <= 64'(mul_p) + lem_pkg::COEF_C;
          state <= S_H3;
        end
        S_H3: begin
          p     <= 64'(mul_p) + lem_pkg::COEF_D;
          state <= S_FIN1;
        end
        S_FIN1: begin
          // low part: (lo*x) >> 24
          acc   <= 64'(mul_p) >> 24;
          state <= S_FIN2;
        end
        S_FIN2: begin
          logic [63:0] r;
          r = (64'(mul_p) + acc) >> 24;
          if (p <= 0) lux <= 16'd0;
          else if (r > 64'(lem_pkg::LUX_MAX)) lux <= lem_pkg::LUX_MAX;
          else lux <= r[15:0];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/light_exposure_monitor.sv
// ----------------------------------------------------------------------------
// light_exposure_monitor
// Slot lux averaging, daily peak and in-band minute tracking, exposure flags.
// ----------------------------------------------------------------------------
// Each reading is converted in turn by the lux unit (scaling, then Horner
//   steps and final shifts above 1000 lux), then averaging, bookkeeping
//   and flag states follow before the result is valid
// throughput: one item at a time; next item accepted once the result is taken
// reset: synchronous; clears slot, day, window, peak, count and ring,
//   registers return to category 1, 8 ideal hours, average-peak check
`default_nettype none

module light_exposure_monitor #(
  parameter int SLOTS_PER_DAY = 144,
  parameter int DAYS_KEPT     = 3,
  parameter int WINDOW_SLOTS  = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  lem_in_if.sink           in_ch,
  lem_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  localparam int DW = (DAYS_KEPT > 1) ? $clog2(DAYS_KEPT) : 1;
  localparam int WSW = $clog2(WINDOW_SLOTS * 65536);
  localparam int DSW = $clog2(DAYS_KEPT * 65536 + 1);
  localparam int MSW = $clog2(DAYS_KEPT * 2048 + 1);

  // reciprocal constants for the constant divisions, exact over each sum width
  localparam int WK = WSW + $clog2(WINDOW_SLOTS);
  localparam int DK = DSW + $clog2(DAYS_KEPT);
  localparam int MK = MSW + $clog2(DAYS_KEPT);
  localparam longint unsigned WM =
    ((64'd1 << WK) + 64'(WINDOW_SLOTS) - 64'd1) / 64'(WINDOW_SLOTS);
  localparam longint unsigned DM =
    ((64'd1 << DK) + 64'(DAYS_KEPT) - 64'd1) / 64'(DAYS_KEPT);
  localparam longint unsigned MM =
    ((64'd1 << MK) + 64'(DAYS_KEPT) - 64'd1) / 64'(DAYS_KEPT);
  localparam logic [17:0] DIV3_MUL = 18'd174763;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_AVG  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FLAG = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] category;
  logic [4:0] ideal_hours;
  logic       check_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      category    <= 3'd1;
      ideal_hours <= 5'd8;
      check_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lem_pkg::REG_CATEGORY: category    <= cfg_data[2:0];
        lem_pkg::REG_IDEAL:    ideal_hours <= cfg_data;
        lem_pkg::REG_MODE:     check_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [2:0]  state;
  logic [1:0]  rd_sel;
  logic [47:0] raws;
  logic [17:0] lux_sum;
  logic [15:0] lux;
  logic [7:0]  slot_index;
  logic [DW-1:0] day_index;
  logic [15:0] recent [WINDOW_SLOTS-1];
  logic [15:0] running_peak;
  logic [7:0]  in_band_count;
  logic [10:0] day_minutes [DAYS_KEPT];
  logic [15:0] day_peaks [DAYS_KEPT];

  logic        lu_start, lu_done;
  logic [15:0] lu_lux;
  logic [15:0] lu_raw;

  assign lu_raw = raws[16*rd_sel +: 16];

  lem_lux_unit u_lux (
    .clk(clk), .rst(rst), .start(lu_start), .raw(lu_raw),
    .done(lu_done), .lux(lu_lux)
  );

  assign in_ch.ready = (state == S_IDLE);

  // sum of three readings divided by 3
  logic [35:0] div3_prod;
  assign div3_prod = 36'(lux_sum) * 36'(DIV3_MUL);

  // window sum and ring sums
  logic [WSW-1:0] wsum;
  logic [DSW-1:0] psum;
  logic [MSW-1:0] msum;
  always_comb begin
    wsum = WSW'(lux);
    for (int i = 0; i < WINDOW_SLOTS - 1; i++) wsum = wsum + WSW'(recent[i]);
    psum = '0;
    msum = '0;
    for (int i = 0; i < DAYS_KEPT; i++) begin
      psum = psum + DSW'(day_peaks[i]);
      msum = msum + MSW'(day_minutes[i]);
    end
  end

  // averages by reciprocal multiplication
  logic [WSW+WK:0] wprod;
  logic [DSW+DK:0] pprod;
  logic [MSW+MK:0] mprod;
  logic [15:0]     wavg;
  logic [15:0]     pavg;
  logic [10:0]     mavg;
  assign wprod = (WSW+WK+1)'(wsum) * (WSW+WK+1)'(WM);
  assign pprod = (DSW+DK+1)'(psum) * (DSW+DK+1)'(DM);
  assign mprod = (MSW+MK+1)'(msum) * (MSW+MK+1)'(MM);
  assign wavg  = 16'(wprod >> WK);
  assign pavg  = 16'(pprod >> DK);
  assign mavg  = 11'(mprod >> MK);

  lem_pkg::band_t band;
  assign band = lem_pkg::band_of(category);

  logic signed [12:0] ideal_min;
  assign ideal_min = 13'(ideal_hours) * 13'sd60;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_ch.valid  <= 1'b0;
      lu_start      <= 1'b0;
      slot_index    <= '0;
      day_index     <= '0;
      running_peak  <= '0;
      in_band_count <= '0;
      for (int i = 0; i < WINDOW_SLOTS - 1; i++) recent[i] <= '0;
      for (int i = 0; i < DAYS_KEPT; i++) begin
        day_minutes[i] <= '0;
        day_peaks[i]   <= '0;
      end
    end else begin
      lu_start <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid) begin
          raws     <= {in_ch.raw_third, in_ch.raw_second, in_ch.raw_first};
          rd_sel   <= 2'd0;
          lux_sum  <= '0;
          lu_start <= 1'b1;
          state    <= S_WAIT;
        end
        S_CONV: begin
          lu_start <= 1'b1;
          state    <= S_WAIT;
        end
        S_WAIT: if (lu_done) begin
          if (rd_sel == 2'd2) begin
            state <= S_AVG;
          end else begin
            state <= S_CONV;
          end
          lux_sum <= lux_sum + 18'(lu_lux);
          rd_sel  <= rd_sel + 2'd1;
        end
        S_AVG: begin
          lux   <= div3_prod[34:19];
          state <= S_UPD;
        end
        S_UPD: begin
          logic [15:0] peak_n;
          logic [7:0]  cnt_n;
          logic [11:0] m;
          peak_n = running_peak;
          if (slot_index >= 8'(WINDOW_SLOTS - 1)) begin
            if (wavg > running_peak)
              peak_n = wavg;
          end
          for (int i = WINDOW_SLOTS - 2; i > 0; i--) recent[i] <= recent[i-1];
          recent[0] <= lux;
          cnt_n = in_band_count;
          if (17'(lux) < band.high && 17'(lux) > band.low && in_band_count != 8'hFF)
            cnt_n = in_band_count + 8'd1;
          out_ch.slot_number <= slot_index;
          out_ch.slot_lux    <= lux;
          if (slot_index >= 8'(SLOTS_PER_DAY - 1)) begin
            m = 12'(cnt_n) * 12'd10;
            day_peaks[day_index]   <= peak_n;
            day_minutes[day_index] <= (m > 12'd2047) ? 11'd2047 : m[10:0];
            running_peak  <= '0;
            in_band_count <= '0;
            day_index <= (day_index == DW'(DAYS_KEPT - 1)) ? '0 : day_index + 1'b1;
            slot_index <= '0;
            out_ch.day_closed <= 1'b1;
          end else begin
            running_peak  <= peak_n;
            in_band_count <= cnt_n;
            slot_index    <= slot_index + 8'd1;
            out_ch.day_closed <= 1'b0;
          end
          state <= S_FLAG;
        end
        S_FLAG: begin
          logic [15:0] chk;
          logic signed [13:0] am;
          chk = check_mode ? lux : pavg;
          am  = 14'(mavg);
          out_ch.too_bright      <= 17'(chk) > band.high;
          out_ch.too_dark        <= 17'(chk) < band.low;
          out_ch.too_little_time <= am < 14'(ideal_min) - 14'sd60;
          out_ch.too_much_time   <= am > 14'(ideal_min) + 14'sd60;
          out_ch.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
